[sv/cbcf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package cbcf_pkg;

    // Field and store widths.
    localparam int MASK_W    = 12;
    localparam int BIT_W     = 4;
    localparam int CELL_W    = 5;
    localparam int CMD_W     = 2;
    localparam int CFG_IDX_W = 2;
    localparam int BYTE_W    = 8;
    localparam int CRC_W     = 15;

    // Default number of cells handled by one monitor chip.
    localparam int CELLS_PER_CHIP_DEF = 12;

    // Frame layout.
    localparam int FRAME_LEN = 12;
    localparam int IDX_W     = 4;

    localparam logic [IDX_W-1:0] IDX_CMD_HI  = 4'd0;
    localparam logic [IDX_W-1:0] IDX_CMD_LO  = 4'd1;
    localparam logic [IDX_W-1:0] IDX_PEC0_HI = 4'd2;
    localparam logic [IDX_W-1:0] IDX_PEC0_LO = 4'd3;
    localparam logic [IDX_W-1:0] IDX_CFG0    = 4'd4;
    localparam logic [IDX_W-1:0] IDX_CFG1    = 4'd5;
    localparam logic [IDX_W-1:0] IDX_CFG2    = 4'd6;
    localparam logic [IDX_W-1:0] IDX_CFG3    = 4'd7;
    localparam logic [IDX_W-1:0] IDX_MASK_LO = 4'd8;
    localparam logic [IDX_W-1:0] IDX_MASK_HI = 4'd9;
    localparam logic [IDX_W-1:0] IDX_PEC1_HI = 4'd10;
    localparam logic [IDX_W-1:0] IDX_PEC1_LO = 4'd11;

    // Write configuration command word.
    localparam logic [BYTE_W-1:0] WRCFG_HI = 8'h00;
    localparam logic [BYTE_W-1:0] WRCFG_LO = 8'h01;

    // Packet error code polynomial and seed.
    localparam logic [CRC_W-1:0] PEC_POLY = 15'h4599;
    localparam logic [CRC_W-1:0] PEC_SEED = 15'h0010;

    // Configuration register indexes and reset values.
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_BYTE0 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_BYTE1 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_BYTE2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_BYTE3 = 2'd3;

    localparam logic [BYTE_W-1:0] CFG_RST_BYTE0 = 8'h00;
    localparam logic [BYTE_W-1:0] CFG_RST_BYTE1 = 8'hD6;
    localparam logic [BYTE_W-1:0] CFG_RST_BYTE2 = 8'h06;
    localparam logic [BYTE_W-1:0] CFG_RST_BYTE3 = 8'hA4;

    // Commands.
    typedef enum logic [CMD_W-1:0] {
        CMD_START    = 2'd0,
        CMD_STOP     = 2'd1,
        CMD_STOP_ALL = 2'd2
    } cmd_t;

    // One frame job handed from the front to the back.
    typedef struct packed {
        logic              both;
        logic              chip;
        logic [MASK_W-1:0] mask;
    } job_t;

    // Configuration bytes as seen by the serializer.
    typedef struct packed {
        logic [BYTE_W-1:0] byte0;
        logic [BYTE_W-1:0] byte1;
        logic [BYTE_W-1:0] byte2;
        logic [BYTE_W-1:0] byte3;
    } cfg_t;

    // Runs one byte, MSB first, through the CRC-15 remainder.
    function automatic logic [CRC_W-1:0] pec_step(input logic [CRC_W-1:0] rem_in,
                                                 input logic [BYTE_W-1:0] data);
        logic [CRC_W-1:0] rem;
        logic             din;
        rem = rem_in;
        for (int b = BYTE_W - 1; b >= 0; b--) begin
            din = data[b] ^ rem[CRC_W-1];
            rem = {rem[CRC_W-2:0], 1'b0};
            if (din)
            begin
                rem = rem ^ PEC_POLY;
            end
        end
        return rem;
    endfunction

endpackage

`default_nettype wire

[sv/cell_balance_config_framer.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel   | Handshake            | Payload
// ----------+----------------------+-------------------------------------
// input     | push / full          | cmd, cell_index
// result    | empty / pop          | chip_select, frame_byte, last
// config    | cfg_write            | cfg_index, cfg_data
//
// A start or stop command on a cell in range gives 12 frame bytes, stop all
// 24, one byte per cycle while pop keeps up, set by the serializer with its
// running PEC. The first byte goes via the queue, job and output registers.
// A two-entry job queue lets commands be pushed while bytes still stream out.
// Reset clears both discharge masks and loads the default configuration.

module cell_balance_config_framer #(
    parameter int CELLS_PER_CHIP = cbcf_pkg::CELLS_PER_CHIP_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           push,
    output logic                                full,
    input  wire logic [cbcf_pkg::CMD_W-1:0]     cmd,
    input  wire logic [cbcf_pkg::CELL_W-1:0]    cell_index,
    input  wire logic                           cfg_write,
    input  wire logic [cbcf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [cbcf_pkg::BYTE_W-1:0]    cfg_data,
    output logic                                empty,
    input  wire logic                           pop,
    output logic                                chip_select,
    output logic [cbcf_pkg::BYTE_W-1:0]         frame_byte,
    output logic                                last
);
    import cbcf_pkg::*;

    cfg_t cfg_reg, cfg_next;
    logic accept;
    logic job_valid;
    job_t front_job;
    job_t queue_job;
    logic job_take;
    logic queue_empty;

    assign accept = push && !full;

    // Configuration register file.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                CFG_IDX_BYTE0: cfg_next.byte0 = cfg_data;
                CFG_IDX_BYTE1: cfg_next.byte1 = cfg_data;
                CFG_IDX_BYTE2: cfg_next.byte2 = cfg_data;
                CFG_IDX_BYTE3: cfg_next.byte3 = cfg_data;
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.byte0 <= CFG_RST_BYTE0;
            cfg_reg.byte1 <= CFG_RST_BYTE1;
            cfg_reg.byte2 <= CFG_RST_BYTE2;
            cfg_reg.byte3 <= CFG_RST_BYTE3;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front: mask update and job building.
    cbcf_front #(
        .CELLS_PER_CHIP (CELLS_PER_CHIP)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .cmd        (cmd),
        .cell_index (cell_index),
        .job_valid  (job_valid),
        .job        (front_job)
    );

    // Job queue between front and back.
    cbcf_job_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (job_valid),
        .wr_job (front_job),
        .rd_en  (job_take),
        .rd_job (queue_job),
        .full   (full),
        .empty  (queue_empty)
    );

    // Back: frame serializer with output word register.
    cbcf_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .job_avail   (!queue_empty),
        .job_in      (queue_job),
        .job_take    (job_take),
        .pop         (pop),
        .empty       (empty),
        .chip_select (chip_select),
        .frame_byte  (frame_byte),
        .last        (last)
    );

endmodule

`default_nettype wire

[sv/cbcf_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module cbcf_front #(
    parameter int CELLS_PER_CHIP = cbcf_pkg::CELLS_PER_CHIP_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        accept,
    input  wire logic [cbcf_pkg::CMD_W-1:0]  cmd,
    input  wire logic [cbcf_pkg::CELL_W-1:0] cell_index,
    output logic                             job_valid,
    output cbcf_pkg::job_t                   job
);
    import cbcf_pkg::*;

    localparam logic [CELL_W-1:0] LIM0 = CELL_W'(CELLS_PER_CHIP);
    localparam logic [CELL_W-1:0] LIM1 = CELL_W'(2 * CELLS_PER_CHIP);

    logic [MASK_W-1:0] mask0_reg, mask0_next;
    logic [MASK_W-1:0] mask1_reg, mask1_next;
    logic [CELL_W-1:0] cell_off;
    logic [BIT_W-1:0]  bit_sel;
    logic [MASK_W-1:0] bit_onehot;
    logic              in_chip0;
    logic              in_chip1;

    // Classify the cell into a chip and a bit position.
    assign in_chip0   = (cell_index < LIM0);
    assign in_chip1   = !in_chip0 && (cell_index < LIM1);
    assign cell_off   = in_chip0 ? cell_index : (cell_index - LIM0);
    assign bit_sel    = cell_off[BIT_W-1:0];
    assign bit_onehot = MASK_W'(1) << bit_sel;

    // Update the masks and build the frame job.
    always_comb
    begin
        mask0_next = mask0_reg;
        mask1_next = mask1_reg;
        job_valid  = 1'b0;
        job        = '0;
        if (accept)
        begin
            case (cmd_t'(cmd))
                CMD_START, CMD_STOP:
                begin
                    if (in_chip0)
                    begin
                        mask0_next = (cmd_t'(cmd) == CMD_START) ? (mask0_reg | bit_onehot)
                                                                : (mask0_reg & ~bit_onehot);
                        job_valid  = 1'b1;
                        job.chip   = 1'b0;
                        job.mask   = mask0_next;
                    end
                    else if (in_chip1)
                    begin
                        mask1_next = (cmd_t'(cmd) == CMD_START) ? (mask1_reg | bit_onehot)
                                                                : (mask1_reg & ~bit_onehot);
                        job_valid  = 1'b1;
                        job.chip   = 1'b1;
                        job.mask   = mask1_next;
                    end
                end
                CMD_STOP_ALL:
                begin
                    mask0_next = '0;
                    mask1_next = '0;
                    job_valid  = 1'b1;
                    job.both   = 1'b1;
                end
                default:
                begin
                    job_valid = 1'b0;
                end
            endcase
        end
    end

    // Discharge mask registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask0_reg <= '0;
            mask1_reg <= '0;
        end
        else
        begin
            mask0_reg <= mask0_next;
            mask1_reg <= mask1_next;
        end
    end

endmodule

`default_nettype wire

[sv/cbcf_job_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module cbcf_job_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           wr_en,
    input  wire cbcf_pkg::job_t wr_job,
    input  wire logic           rd_en,
    output cbcf_pkg::job_t      rd_job,
    output logic                full,
    output logic                empty
);
    import cbcf_pkg::*;

    // Two entries, one bit pointers.
    job_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full   = (count_reg == 2'd2);
    assign empty  = (count_reg == 2'd0);
    assign rd_job = entry_reg[rd_ptr_reg];

    // Pointer and fill count bookkeeping.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ wr_en;
        rd_ptr_next = rd_ptr_reg ^ rd_en;
        count_next  = count_reg + {1'b0, wr_en} - {1'b0, rd_en};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_reg[wr_ptr_reg] <= wr_job;
        end
    end

endmodule

`default_nettype wire

[sv/cbcf_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module cbcf_back (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire cbcf_pkg::cfg_t              cfg,
    input  wire logic                        job_avail,
    input  wire cbcf_pkg::job_t              job_in,
    output logic                             job_take,
    input  wire logic                        pop,
    output logic                             empty,
    output logic                             chip_select,
    output logic [cbcf_pkg::BYTE_W-1:0]      frame_byte,
    output logic                             last
);
    import cbcf_pkg::*;

    logic              active_reg, active_next;
    logic              second_reg, second_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [CRC_W-1:0]  crc_reg, crc_next;
    job_t              job_reg, job_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_chip_reg, out_chip_next;
    logic [BYTE_W-1:0] out_byte_reg, out_byte_next;
    logic              out_last_reg, out_last_next;
    logic              advance;
    logic              frame_end;
    logic              item_end;
    logic [BYTE_W-1:0] cur_byte;
    logic [MASK_W-1:0] cur_mask;

    assign empty       = !out_valid_reg;
    assign chip_select = out_chip_reg;
    assign frame_byte  = out_byte_reg;
    assign last        = out_last_reg;

    // The output word register frees up when it is empty or being popped.
    assign advance   = !out_valid_reg || pop;
    assign frame_end = (idx_reg == IDX_PEC1_LO);
    assign item_end  = frame_end && (!job_reg.both || second_reg);
    assign cur_mask  = job_reg.mask;

    // Select the frame byte for the current position.
    always_comb
    begin
        case (idx_reg)
            IDX_CMD_HI:  cur_byte = WRCFG_HI;
            IDX_CMD_LO:  cur_byte = WRCFG_LO;
            IDX_PEC0_HI: cur_byte = crc_reg[CRC_W-1:CRC_W-BYTE_W];
            IDX_PEC0_LO: cur_byte = {crc_reg[CRC_W-BYTE_W-1:0], 1'b0};
            IDX_CFG0:    cur_byte = cfg.byte0;
            IDX_CFG1:    cur_byte = cfg.byte1;
            IDX_CFG2:    cur_byte = cfg.byte2;
            IDX_CFG3:    cur_byte = cfg.byte3;
            IDX_MASK_LO: cur_byte = cur_mask[BYTE_W-1:0];
            IDX_MASK_HI: cur_byte = BYTE_W'(cur_mask[MASK_W-1:BYTE_W]);
            IDX_PEC1_HI: cur_byte = crc_reg[CRC_W-1:CRC_W-BYTE_W];
            IDX_PEC1_LO: cur_byte = {crc_reg[CRC_W-BYTE_W-1:0], 1'b0};
            default:     cur_byte = '0;
        endcase
    end

    // Sequencer: one frame byte per cycle while the output can take it.
    always_comb
    begin
        active_next    = active_reg;
        second_next    = second_reg;
        idx_next       = idx_reg;
        crc_next       = crc_reg;
        job_next       = job_reg;
        job_take       = 1'b0;
        out_valid_next = out_valid_reg && !pop;
        out_chip_next  = out_chip_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;

        if (active_reg && advance)
        begin
            out_valid_next = 1'b1;
            out_chip_next  = second_reg ? 1'b1 : job_reg.chip;
            out_byte_next  = cur_byte;
            out_last_next  = item_end;

            // Running PEC: restart at each group, hold over the PEC bytes.
            case (idx_reg)
                IDX_CMD_HI, IDX_CFG0:
                    crc_next = pec_step(PEC_SEED, cur_byte);
                IDX_CMD_LO, IDX_CFG1, IDX_CFG2, IDX_CFG3, IDX_MASK_LO, IDX_MASK_HI:
                    crc_next = pec_step(crc_reg, cur_byte);
                default:
                    crc_next = crc_reg;
            endcase

            if (!frame_end)
            begin
                idx_next = idx_reg + IDX_W'(1);
            end
            else if (!item_end)
            begin
                second_next = 1'b1;
                idx_next    = IDX_CMD_HI;
            end
            else if (job_avail)
            begin
                job_take    = 1'b1;
                job_next    = job_in;
                second_next = 1'b0;
                idx_next    = IDX_CMD_HI;
            end
            else
            begin
                active_next = 1'b0;
            end
        end
        else if (!active_reg && job_avail)
        begin
            job_take    = 1'b1;
            job_next    = job_in;
            active_next = 1'b1;
            second_next = 1'b0;
            idx_next    = IDX_CMD_HI;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            second_reg    <= 1'b0;
            idx_reg       <= IDX_CMD_HI;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            second_reg    <= second_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        crc_reg      <= crc_next;
        job_reg      <= job_next;
        out_chip_reg <= out_chip_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

endmodule

`default_nettype wire

[verif/cbcf_frame_checker.sv]
`timescale 1ns / 1ps

// Watches the command and frame byte channels of the configuration framer.
// It keeps its own copy of the discharge masks and configuration bytes, builds
// the expected frame bytes for every accepted command word, and compares each
// popped word with the oldest expected one.
module cbcf_frame_checker (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           push,
    input  wire logic                           full,
    input  wire logic [cbcf_pkg::CMD_W-1:0]     cmd,
    input  wire logic [cbcf_pkg::CELL_W-1:0]    cell_index,
    input  wire logic                           cfg_write,
    input  wire logic [cbcf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [cbcf_pkg::BYTE_W-1:0]    cfg_data,
    input  wire logic                           empty,
    input  wire logic                           pop,
    input  wire logic                           chip_select,
    input  wire logic [cbcf_pkg::BYTE_W-1:0]    frame_byte,
    input  wire logic                           last,
    output int                                  errors,
    output int                                  owed_count,
    output int                                  words_taken,
    output int                                  bytes_checked
);
    import cbcf_pkg::*;

    localparam int CELLS = CELLS_PER_CHIP_DEF;

    // One frame byte as it should leave the block.
    typedef struct packed {
        logic              chip;
        logic [BYTE_W-1:0] data;
        logic              last;
    } frame_word_t;

    frame_word_t       owed_bytes[$];
    logic [MASK_W-1:0] mask_chip[2];
    logic [BYTE_W-1:0] cfg_copy[4];
    int                fail_total;
    int                taken_total;
    int                seen_total;

    // CRC-15 over the lowest nbytes bytes of the vector, first byte highest,
    // each byte MSB first; the 15-bit remainder comes back shifted left by one.
    function automatic logic [15:0] pec_over(input logic [47:0] bytes_in, input int nbytes);
        logic [CRC_W-1:0] rem;
        logic             feedback;
        rem = PEC_SEED;
        for (int i = nbytes * 8 - 1; i >= 0; i--)
        begin
            feedback = bytes_in[i] ^ rem[CRC_W-1];
            rem = {rem[CRC_W-2:0], 1'b0};
            if (feedback)
            begin
                rem = rem ^ PEC_POLY;
            end
        end
        return {rem, 1'b0};
    endfunction

    // Appends the twelve bytes of one configuration write frame.
    task automatic queue_frame(input logic chip, input logic [MASK_W-1:0] mask,
                               input logic ends_item);
        logic [BYTE_W-1:0] fb[FRAME_LEN];
        logic [15:0]       pec;
        frame_word_t       w;
        fb[0] = WRCFG_HI;
        fb[1] = WRCFG_LO;
        pec = pec_over({32'd0, fb[0], fb[1]}, 2);
        fb[2] = pec[15:8];
        fb[3] = pec[7:0];
        fb[4] = cfg_copy[CFG_IDX_BYTE0];
        fb[5] = cfg_copy[CFG_IDX_BYTE1];
        fb[6] = cfg_copy[CFG_IDX_BYTE2];
        fb[7] = cfg_copy[CFG_IDX_BYTE3];
        fb[8] = mask[7:0];
        fb[9] = {4'h0, mask[11:8]};
        pec = pec_over({fb[4], fb[5], fb[6], fb[7], fb[8], fb[9]}, 6);
        fb[10] = pec[15:8];
        fb[11] = pec[7:0];
        for (int i = 0; i < FRAME_LEN; i++)
        begin
            w.chip = chip;
            w.data = fb[i];
            w.last = ends_item && (i == FRAME_LEN - 1);
            owed_bytes.push_back(w);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        frame_word_t want;
        logic        chip;
        int          bitpos;
        logic        mismatch;
        if (!rst_n)
        begin
            mask_chip[0] = '0;
            mask_chip[1] = '0;
            cfg_copy[CFG_IDX_BYTE0] = CFG_RST_BYTE0;
            cfg_copy[CFG_IDX_BYTE1] = CFG_RST_BYTE1;
            cfg_copy[CFG_IDX_BYTE2] = CFG_RST_BYTE2;
            cfg_copy[CFG_IDX_BYTE3] = CFG_RST_BYTE3;
            owed_bytes.delete();
        end
        else
        begin
            // The user must keep configuration writes to while the framer is idle; the framer does not enforce this.
            if (cfg_write)
            begin
                cfg_copy[cfg_index] = cfg_data;
            end

            // Predict the frames caused by an accepted command word.
            if (push && !full)
            begin
                taken_total++;
                case (cmd)
                    CMD_START, CMD_STOP:
                    begin
                        if (cell_index < 2 * CELLS)
                        begin
                            chip = (cell_index >= CELLS);
                            bitpos = chip ? cell_index - CELLS : cell_index;
                            mask_chip[chip][bitpos] = (cmd == CMD_START);
                            queue_frame(chip, mask_chip[chip], 1'b1);
                        end
                    end
                    CMD_STOP_ALL:
                    begin
                        mask_chip[0] = '0;
                        mask_chip[1] = '0;
                        queue_frame(1'b0, mask_chip[0], 1'b0);
                        queue_frame(1'b1, mask_chip[1], 1'b1);
                    end
                    default:
                    begin
                    end
                endcase
            end

            // Compare a popped frame byte with the oldest expected one.
            if (pop && !empty)
            begin
                if (owed_bytes.size() == 0)
                begin
                    $error("unexpected frame byte 0x%02h for chip %0d", frame_byte, chip_select);
                    fail_total++;
                end
                else
                begin
                    want = owed_bytes.pop_front();
                    mismatch = 1'b0;
                    if (chip_select !== want.chip)
                    begin
                        $error("chip_select: expected %0d, got %0d", want.chip, chip_select);
                        mismatch = 1'b1;
                    end
                    if (frame_byte !== want.data)
                    begin
                        $error("frame_byte: expected 0x%02h, got 0x%02h", want.data, frame_byte);
                        mismatch = 1'b1;
                    end
                    if (last !== want.last)
                    begin
                        $error("last: expected %0d, got %0d", want.last, last);
                        mismatch = 1'b1;
                    end
                    if (mismatch)
                    begin
                        fail_total++;
                    end
                    seen_total++;
                end
            end
        end
        errors        <= fail_total;
        owed_count    <= owed_bytes.size();
        words_taken   <= taken_total;
        bytes_checked <= seen_total;
    end

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps

module tb;
    import cbcf_pkg::*;

    localparam int                 CELLS        = CELLS_PER_CHIP_DEF;
    localparam logic [CMD_W-1:0]   CMD_UNUSED   = 2'd3;
    localparam int                 DRAIN_CYCLES = 8;
    localparam int                 CYCLE_LIMIT  = 2000000;
    localparam int                 PHASE_WORDS  = 62;

    logic                 clk         = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 push        = 1'b0;
    logic [CMD_W-1:0]     cmd         = '0;
    logic [CELL_W-1:0]    cell_index  = '0;
    logic                 cfg_write   = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index   = '0;
    logic [BYTE_W-1:0]    cfg_data    = '0;
    logic                 pop         = 1'b0;
    wire logic            full;
    wire logic            empty;
    wire logic            chip_select;
    wire logic [BYTE_W-1:0] frame_byte;
    wire logic            last;

    int errors;
    int owed_count;
    int words_taken;
    int bytes_checked;
    int cycles         = 0;
    int push_idle_pct  = 0;
    int pop_stall_pct  = 0;
    int pop_wait       = 0;
    int directed_words = 0;

    cell_balance_config_framer uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .cmd         (cmd),
        .cell_index  (cell_index),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .empty       (empty),
        .pop         (pop),
        .chip_select (chip_select),
        .frame_byte  (frame_byte),
        .last        (last)
    );

    cbcf_frame_checker frame_chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .cmd           (cmd),
        .cell_index    (cell_index),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .empty         (empty),
        .pop           (pop),
        .chip_select   (chip_select),
        .frame_byte    (frame_byte),
        .last          (last),
        .errors        (errors),
        .owed_count    (owed_count),
        .words_taken   (words_taken),
        .bytes_checked (bytes_checked)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        if ($urandom_range(0, 99) < 80)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // The result side stalls at random; pop stays high when stalls are off.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else if (pop_wait > 0)
        begin
            pop <= 1'b0;
            pop_wait--;
        end
        else if ($urandom_range(0, 99) < pop_stall_pct)
        begin
            pop <= 1'b0;
            pop_wait = pick_gap() - 1;
        end
        else
        begin
            pop <= 1'b1;
        end
    end

    // Guard against a hung run.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Offers one command word and returns after the first clock edge that leaves
    // full low. Push stays high so that words can follow back to back.
    task automatic send_word(input logic [CMD_W-1:0] c, input logic [CELL_W-1:0] ci);
        int gap;
        gap = 0;
        if ($urandom_range(0, 99) < push_idle_pct)
        begin
            gap = pick_gap();
        end
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        cmd <= c;
        cell_index <= ci;
        @(posedge clk);
        while (full)
        begin
            @(posedge clk);
        end
    endtask

    // Waits until every expected byte is out, then lets ignored words settle.
    task automatic wait_drained();
        do
        begin
            @(posedge clk);
        end
        while (owed_count != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Loads all four configuration bytes; the framer must be idle.
    task automatic load_config(input logic [BYTE_W-1:0] b0, input logic [BYTE_W-1:0] b1,
                               input logic [BYTE_W-1:0] b2, input logic [BYTE_W-1:0] b3);
        logic [BYTE_W-1:0] vals[4];
        vals[CFG_IDX_BYTE0] = b0;
        vals[CFG_IDX_BYTE1] = b1;
        vals[CFG_IDX_BYTE2] = b2;
        vals[CFG_IDX_BYTE3] = b3;
        for (int i = 0; i < 4; i++)
        begin
            cfg_write <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data <= vals[i];
            @(posedge clk);
        end
        cfg_write <= 1'b0;
    endtask

    // One random word; mostly in-range start and stop, some noise.
    // Returns 1 when the word causes frame bytes.
    task automatic send_random(output logic framed);
        int pick;
        pick = $urandom_range(0, 99);
        framed = 1'b1;
        if (pick < 42)
        begin
            send_word(CMD_START, CELL_W'($urandom_range(0, 2 * CELLS - 1)));
        end
        else if (pick < 74)
        begin
            send_word(CMD_STOP, CELL_W'($urandom_range(0, 2 * CELLS - 1)));
        end
        else if (pick < 82)
        begin
            send_word(CMD_STOP_ALL, CELL_W'($urandom));
        end
        else if (pick < 91)
        begin
            send_word($urandom_range(0, 1) ? CMD_START : CMD_STOP,
                      CELL_W'($urandom_range(2 * CELLS, 31)));
            framed = 1'b0;
        end
        else
        begin
            send_word(CMD_UNUSED, CELL_W'($urandom));
            framed = 1'b0;
        end
    endtask

    initial
    begin
        int   framed_words;
        logic framed;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words under the reset configuration: mask edges on both
        // chips, out-of-range cells, the unused command and stop all.
        push_idle_pct = 0;
        pop_stall_pct = 0;
        send_word(CMD_START, 5'd0);
        send_word(CMD_START, 5'd11);
        send_word(CMD_START, 5'd12);
        send_word(CMD_START, 5'd23);
        send_word(CMD_START, 5'd7);
        send_word(CMD_STOP, 5'd11);
        send_word(CMD_STOP, 5'd23);
        send_word(CMD_STOP, 5'd7);
        send_word(CMD_START, 5'd24);
        send_word(CMD_STOP, 5'd31);
        send_word(CMD_UNUSED, 5'd5);
        send_word(CMD_UNUSED, 5'd31);
        send_word(CMD_STOP_ALL, 5'd31);
        send_word(CMD_STOP, 5'd0);
        send_word(CMD_STOP_ALL, 5'd0);
        for (int i = 0; i < 2 * CELLS; i += 3)
        begin
            send_word(CMD_START, CELL_W'(i));
        end
        send_word(CMD_START, 5'd16);
        push <= 1'b0;
        directed_words = words_taken + 1;
        wait_drained();

        // Random phases: the first keeps the reset configuration, the others each load a fresh one.
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                1: load_config(8'h00, 8'h00, 8'h00, 8'h00);
                2: load_config(8'hFF, 8'hFF, 8'hFF, 8'hFF);
                3: load_config(BYTE_W'($urandom), BYTE_W'($urandom),
                               BYTE_W'($urandom), BYTE_W'($urandom));
                default: ;
            endcase
            push_idle_pct = (ph == 1) ? 0 : 30;
            pop_stall_pct = (ph == 1) ? 0 : 20;
            framed_words = 0;
            while (framed_words < PHASE_WORDS)
            begin
                send_random(framed);
                if (framed)
                begin
                    framed_words++;
                end
            end
            push <= 1'b0;
            wait_drained();
        end

        $display("Sent %0d command words (%0d directed) over four configuration settings,",
                 words_taken, directed_words);
        $display("including all-zero and all-one bytes; %0d frame bytes were checked.",
                 bytes_checked);
        if (errors == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
